>>> hdl/tlnef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlnef_pkg
// Shared types and constants for the text line number and escape filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

    localparam logic [1:0] NUM_MODE_ALL      = 2'd1;
    localparam logic [1:0] NUM_MODE_NONEMPTY = 2'd2;

    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_I        = 8'h49;
    localparam logic [7:0] CHAR_CARET    = 8'h5E;
    localparam logic [7:0] CHAR_DELETE   = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT    = 8'd32;
    localparam logic [7:0] CARET_OFFSET  = 8'd64;

    // One queued transaction: an optional line number, an optional prefix
    // byte and the byte that closes the run.
    typedef struct packed {
        logic       num_en;
        logic       pre_en;
        logic [7:0] pre_byte;
        logic [7:0] main_byte;
    } cmd_t;

    typedef enum logic [4:0] {
        PH_HEAD  = 5'b00001,
        PH_DIGIT = 5'b00010,
        PH_TAB   = 5'b00100,
        PH_PRE   = 5'b01000,
        PH_MAIN  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_status_t;

endpackage

>>> hdl/tlnef_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlnef_front
// Holds the option registers and line state, classifies each input byte and
// turns it into a queued command for the output sequencer.
// ----------------------------------------------------------------------------
module tlnef_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [tlnef_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlnef_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_in_byte,
    input  logic                               q_full,
    output logic                               q_push,
    output tlnef_pkg::cmd_t                    q_cmd,
    output logic [4*NUMBER_DIGITS-1:0]         q_number
);
    import tlnef_pkg::*;

    localparam int NUM_W = 4 * NUMBER_DIGITS;

    logic [1:0]       number_mode_reg;
    logic             squeeze_blank_reg;
    logic             show_ends_reg;
    logic             show_tabs_reg;
    logic             show_nonprinting_reg;
    logic [NUM_W-1:0] line_number_reg, line_number_next;
    logic             at_line_start_reg, at_line_start_next;
    logic [1:0]       newline_run_reg, newline_run_next;

    logic             accept;
    logic             is_nl;
    logic             drop;
    logic             num_en;
    logic [NUM_W-1:0] bumped;
    logic             carry;
    cmd_t             cmd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_nl   = (s_in_byte == CHAR_NEWLINE);
    // A newline after an empty line is swallowed when squeezing.
    assign drop    = is_nl && squeeze_blank_reg && newline_run_reg[1];
    assign num_en  = at_line_start_reg &&
                     ((number_mode_reg == NUM_MODE_ALL) ||
                      ((number_mode_reg == NUM_MODE_NONEMPTY) && !is_nl));

    // Decimal increment with ripple carry, wrapping after all nines.
    always_comb begin
        bumped = line_number_reg;
        carry  = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry) begin
                if (line_number_reg[4*i +: 4] < 4'd9) begin
                    bumped[4*i +: 4] = line_number_reg[4*i +: 4] + 4'd1;
                    carry            = 1'b0;
                end else begin
                    bumped[4*i +: 4] = 4'd0;
                end
            end
        end
    end

    always_comb begin
        cmd.num_en    = num_en;
        cmd.pre_en    = 1'b0;
        cmd.pre_byte  = CHAR_CARET;
        cmd.main_byte = s_in_byte;
        if (is_nl) begin
            cmd.pre_en   = show_ends_reg;
            cmd.pre_byte = CHAR_DOLLAR;
        end else if (s_in_byte == CHAR_TAB) begin
            if (show_tabs_reg) begin
                cmd.pre_en    = 1'b1;
                cmd.main_byte = CHAR_I;
            end
        end else if (show_nonprinting_reg && (s_in_byte < CTRL_LIMIT)) begin
            cmd.pre_en    = 1'b1;
            cmd.main_byte = s_in_byte + CARET_OFFSET;
        end else if (show_nonprinting_reg && (s_in_byte == CHAR_DELETE)) begin
            cmd.pre_en    = 1'b1;
            cmd.main_byte = CHAR_QUESTION;
        end
    end

    always_comb begin
        line_number_next   = line_number_reg;
        at_line_start_next = at_line_start_reg;
        newline_run_next   = newline_run_reg;
        if (accept && !drop) begin
            if (num_en) begin
                line_number_next = bumped;
            end
            if (is_nl) begin
                at_line_start_next = 1'b1;
                if (!newline_run_reg[1]) begin
                    newline_run_next = newline_run_reg + 2'd1;
                end
            end else begin
                at_line_start_next = 1'b0;
                newline_run_next   = 2'd0;
            end
        end
    end

    assign q_push   = accept && !drop;
    assign q_cmd    = cmd;
    assign q_number = line_number_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_mode_reg      <= 2'd0;
            squeeze_blank_reg    <= 1'b0;
            show_ends_reg        <= 1'b0;
            show_tabs_reg        <= 1'b0;
            show_nonprinting_reg <= 1'b0;
            line_number_reg      <= NUM_W'(1);
            at_line_start_reg    <= 1'b1;
            newline_run_reg      <= 2'd1;
        end else begin
            line_number_reg   <= line_number_next;
            at_line_start_reg <= at_line_start_next;
            newline_run_reg   <= newline_run_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_NUMBER_MODE:      number_mode_reg      <= cfg_data[1:0];
                    CFG_SQUEEZE_BLANK:    squeeze_blank_reg    <= cfg_data[0];
                    CFG_SHOW_ENDS:        show_ends_reg        <= cfg_data[0];
                    CFG_SHOW_TABS:        show_tabs_reg        <= cfg_data[0];
                    CFG_SHOW_NONPRINTING: show_nonprinting_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> hdl/tlnef_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlnef_fifo
// Small first-word-fall-through queue between the classifier and the
// output sequencer.
// ----------------------------------------------------------------------------
module tlnef_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/tlnef_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlnef_back
// Output sequencer: walks the queued command byte by byte (number digits,
// tab, prefix, final byte) into a registered output stage.
// ----------------------------------------------------------------------------
module tlnef_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  tlnef_pkg::cmd_t             q_cmd,
    input  logic [4*NUMBER_DIGITS-1:0]  q_number,
    output tlnef_pkg::back_status_t     status,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_last_of_run
);
    import tlnef_pkg::*;

    localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    phase_t           phase_reg, phase_next, eff_phase;
    logic [DIG_W-1:0] digit_reg, digit_next, eff_digit;
    logic             seen_reg, seen_next, eff_seen;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_out_byte_reg, m_out_byte_next;
    logic             m_last_reg, m_last_next;

    logic             advance;
    logic [3:0]       digit_val;
    logic [3:0]       digit_clip;
    logic             seen_now;
    logic             pop;

    assign advance = q_valid && (!m_valid_reg || m_ready);

    // At the head of a command, the first phase follows from what it carries.
    always_comb begin
        if (phase_reg == PH_HEAD) begin
            eff_digit = DIG_W'(NUMBER_DIGITS - 1);
            eff_seen  = 1'b0;
            if (q_cmd.num_en) begin
                eff_phase = PH_DIGIT;
            end else if (q_cmd.pre_en) begin
                eff_phase = PH_PRE;
            end else begin
                eff_phase = PH_MAIN;
            end
        end else begin
            eff_digit = digit_reg;
            eff_seen  = seen_reg;
            eff_phase = phase_reg;
        end
    end

    assign digit_val  = q_number[4*eff_digit +: 4];
    assign digit_clip = (digit_val > 4'd9) ? 4'd9 : digit_val;
    assign seen_now   = eff_seen || (digit_val != 4'd0) || (eff_digit == '0);

    always_comb begin
        phase_next      = phase_reg;
        digit_next      = digit_reg;
        seen_next       = seen_reg;
        m_out_byte_next = m_out_byte_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        pop             = 1'b0;
        if (advance) begin
            m_valid_next = 1'b1;
            m_last_next  = 1'b0;
            case (eff_phase)
                PH_DIGIT: begin
                    m_out_byte_next = seen_now ? (CHAR_ZERO + {4'd0, digit_clip}) : CHAR_SPACE;
                    seen_next       = seen_now;
                    if (eff_digit == '0) begin
                        phase_next = PH_TAB;
                    end else begin
                        phase_next = PH_DIGIT;
                        digit_next = eff_digit - DIG_W'(1);
                    end
                end
                PH_TAB: begin
                    m_out_byte_next = CHAR_TAB;
                    phase_next      = q_cmd.pre_en ? PH_PRE : PH_MAIN;
                end
                PH_PRE: begin
                    m_out_byte_next = q_cmd.pre_byte;
                    phase_next      = PH_MAIN;
                end
                PH_MAIN: begin
                    m_out_byte_next = q_cmd.main_byte;
                    m_last_next     = 1'b1;
                    phase_next      = PH_HEAD;
                    pop             = 1'b1;
                end
                default: begin
                    phase_next   = PH_HEAD;
                    m_valid_next = m_valid_reg && !m_ready;
                end
            endcase
        end
    end

    assign status.busy   = (phase_reg != PH_HEAD);
    assign status.pop    = pop;
    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_last_of_run = m_last_reg;

    always_ff @(posedge aclk) begin
        m_out_byte_reg <= m_out_byte_next;
        m_last_reg     <= m_last_next;
        digit_reg      <= digit_next;
        seen_reg       <= seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hdl/text_line_number_escape_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_top
// Byte-stream formatter in the style of cat: optional line numbers, squeezed
// blank lines, '$' at line ends and caret escapes for tabs and controls.
// ----------------------------------------------------------------------------
//  Channel | Direction | Transaction
//  s_      | in        | one raw byte (s_in_byte)
//  m_      | out       | one formatted byte plus end-of-run flag
//  cfg_    | in        | option register write (index, data); always ready
//
// Output bytes leave through the registered output stage. An input byte
// yields one output byte (plain), two (escaped or with '$') and up to
// NUMBER_DIGITS + 3 at a numbered line start. A squeezed newline is absorbed
// in its accept cycle. A four-entry queue lets input keep flowing while the
// output is stalled. Reset is synchronous and clears only the control state.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter_top #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlnef_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlnef_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_in_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_out_byte,
    output logic                               m_last_of_run
);
    import tlnef_pkg::*;

    localparam int NUM_W   = 4 * NUMBER_DIGITS;
    localparam int CMD_W   = $bits(cmd_t);
    localparam int Q_WIDTH = NUM_W + CMD_W;
    localparam int Q_DEPTH = 4;

    logic               q_push;
    logic               q_full;
    logic               q_not_empty;
    cmd_t               push_cmd;
    logic [NUM_W-1:0]   push_number;
    logic [Q_WIDTH-1:0] head_data;
    cmd_t               head_cmd;
    logic [NUM_W-1:0]   head_number;
    back_status_t       back_status;

    assign cfg_ready = 1'b1;

    tlnef_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .q_number  (push_number)
    );

    tlnef_fifo #(
        .WIDTH(Q_WIDTH),
        .DEPTH(Q_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({push_number, push_cmd}),
        .pop       (back_status.pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_data (head_data)
    );

    assign head_cmd    = head_data[CMD_W-1:0];
    assign head_number = head_data[Q_WIDTH-1:CMD_W];

    tlnef_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_not_empty),
        .q_cmd         (head_cmd),
        .q_number      (head_number),
        .status        (back_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    // The sequencer only retires a command that is actually queued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.pop |-> q_not_empty)
        else $error("sequencer popped an empty queue");

    // A command in progress stays at the queue head until its last byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.busy |-> q_not_empty)
        else $error("sequencer busy with no queued command");

    // The classifier never writes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue overflow");

    // Retiring a command always loads a final byte into the output stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.pop |=> m_valid && m_last_of_run)
        else $error("retired command without end-of-run byte");

endmodule
